/* design/autorange_humidity_converter_macros.svh */
// Assertion shorthands; the enclosing module provides clk and rst_n.
`ifndef AUTORANGE_HUMIDITY_CONVERTER_MACROS_SVH
`define AUTORANGE_HUMIDITY_CONVERTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ahc_pkg.sv */
package ahc_pkg;

  localparam int ADC_BITS       = 10;
  localparam int RANGE_COUNT    = 5;
  localparam int RESIDUAL_LIMIT = 4;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration register indexes
  localparam logic CFG_LOG_OFFSET = 1'b0;
  localparam logic CFG_THRESHOLD  = 1'b1;

  localparam logic signed [32:0] LN2_Q30     = 33'sd744261118;
  localparam logic signed [32:0] LOG10_2_Q30 = 33'sd323228497;
  localparam logic signed [51:0] HUNDRED_Q36 = 52'sd6871947673600;
  localparam logic signed [22:0] LOG2_Q46    = 23'sd3014656;

  // Temperature polynomial coefficients, Q.24
  localparam logic signed [34:0] COEF_A0 = 35'sd21224856;
  localparam logic signed [32:0] COEF_A1 = 33'sd932813;
  localparam logic signed [32:0] COEF_A2 = -33'sd11744;
  localparam logic signed [34:0] COEF_B0 = 35'sd621277086;
  localparam logic signed [32:0] COEF_B1 = 33'sd6397152;
  localparam logic signed [32:0] COEF_B2 = -33'sd46976;
  localparam logic signed [34:0] COEF_C0 = 35'sd3471373763;
  localparam logic signed [32:0] COEF_C1 = 33'sd766719;
  localparam logic signed [32:0] COEF_C2 = -33'sd60398;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_NORM,
    S_SQ,
    S_SQW,
    S_LN,
    S_LNW,
    S_POLY,
    S_FINISH
  } ahc_state_t;

  typedef struct packed {
    logic [9:0]  residual;
    logic [9:0]  sample;
    logic [15:0] temperature;
  } ahc_item_t;

  typedef struct packed {
    logic [14:0] humidity;
    logic        done_res;
    logic [2:0]  next_range;
    logic        discharge_error;
  } ahc_res_t;

endpackage

/* design/ahc_mul.sv */
module ahc_mul
  import ahc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* design/ahc_seq.sv */
`include "autorange_humidity_converter_macros.svh"

module ahc_seq
  import ahc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ahc_item_t          item,
  input  logic signed [15:0] log_offset,
  input  logic [9:0]         threshold,
  output logic               busy,
  output logic               res_valid,
  output ahc_res_t           res
);

  ahc_state_t state_r, state_nxt;
  ahc_item_t  item_r, item_nxt;
  logic [2:0] range_r, range_nxt;
  logic       res_valid_r, res_valid_nxt;
  ahc_res_t   res_r, res_nxt;

  logic [49:0] nz_r, nz_nxt;
  logic [5:0]  p_r, p_nxt;
  logic [30:0] z_r, z_nxt;
  logic [21:0] r_r, r_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        pass_r, pass_nxt;
  logic [3:0]  step_r, step_nxt;

  logic signed [18:0] rl_r, rl_nxt;
  logic [31:0]        t2_r, t2_nxt;
  logic [20:0]        rl2_r, rl2_nxt;
  logic signed [34:0] pa_r, pa_nxt;
  logic signed [34:0] pb_r, pb_nxt;
  logic signed [34:0] pc_r, pc_nxt;
  logic signed [51:0] acc_r, acc_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [PROD_W-1:0] prod_sra16, prod_sra8, lg10_w, rl_w;
  logic [31:0]              sq_q;
  logic [21:0]              a_val;
  logic signed [22:0]       l2_w;
  logic signed [51:0]       rnd_w;
  logic                     last_range;

  ahc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign prod_sra16 = mul_p >>> 16;
  assign prod_sra8  = mul_p >>> 8;
  assign lg10_w     = (mul_p + 66'sd8589934592) >>> 34;
  assign rl_w       = PROD_W'(log_offset) - lg10_w + $signed({51'd0, range_r, 12'd0});
  assign sq_q       = mul_p[61:30];
  assign a_val      = 22'(ADC_BITS << 16) - r_r;
  assign l2_w       = $signed({1'b0, r_r}) - LOG2_Q46;
  assign rnd_w      = acc_r + 52'sd134217728;
  assign last_range = ({1'b0, range_r} + 4'd1) >= 4'(RANGE_COUNT);

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    range_nxt     = range_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    nz_nxt        = nz_r;
    p_nxt         = p_r;
    z_nxt         = z_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    step_nxt      = step_r;
    rl_nxt        = rl_r;
    t2_nxt        = t2_r;
    rl2_nxt       = rl2_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    pc_nxt        = pc_r;
    acc_nxt       = acc_r;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = item;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_nxt = '0;
        priority if (item_r.residual > 10'(RESIDUAL_LIMIT)) begin
          range_nxt               = '0;
          res_nxt.done_res        = 1'b1;
          res_nxt.discharge_error = 1'b1;
          res_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else if (item_r.sample <= threshold && !last_range) begin
          range_nxt          = range_r + 3'd1;
          res_nxt.next_range = range_r + 3'd1;
          res_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end else if (item_r.sample == '0) begin
          range_nxt        = '0;
          res_nxt.done_res = 1'b1;
          res_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          nz_nxt    = 50'((1 << ADC_BITS) - int'(item_r.sample));
          p_nxt     = 6'd30;
          pass_nxt  = 1'b0;
          state_nxt = S_NORM;
        end
      end

      // Bring the operand into [2^30, 2^31), one bit a cycle
      S_NORM: begin
        priority if (nz_r[49:31] != '0) begin
          nz_nxt = nz_r >> 1;
          p_nxt  = p_r + 6'd1;
        end else if (nz_r[49:30] == '0) begin
          nz_nxt = nz_r << 1;
          p_nxt  = p_r - 6'd1;
        end else begin
          z_nxt     = nz_r[30:0];
          r_nxt     = {p_r, 16'd0};
          k_nxt     = 4'd15;
          state_nxt = S_SQ;
        end
      end

      S_SQ: begin
        mul_a     = $signed({2'b00, z_r});
        mul_b     = $signed({2'b00, z_r});
        state_nxt = S_SQW;
      end

      // Square result of 2 or more yields a one in this fraction bit
      S_SQW: begin
        if (sq_q[31]) begin
          z_nxt = sq_q[31:1];
          r_nxt = r_r | (22'd1 << k_r);
        end else begin
          z_nxt = sq_q[30:0];
        end
        if (k_r != '0) begin
          k_nxt     = k_r - 4'd1;
          state_nxt = S_SQ;
        end else if (!pass_r) begin
          state_nxt = S_LN;
        end else begin
          step_nxt  = '0;
          state_nxt = S_POLY;
        end
      end

      S_LN: begin
        mul_a     = $signed({11'd0, a_val});
        mul_b     = LN2_Q30;
        r_nxt     = a_val;
        state_nxt = S_LNW;
      end

      S_LNW: begin
        nz_nxt    = mul_p[49:0];
        p_nxt     = 6'd30;
        pass_nxt  = 1'b1;
        state_nxt = S_NORM;
      end

      // Each step but the last issues one product; each step but the first takes in the previous step's product
      S_POLY: begin
        step_nxt = step_r + 4'd1;
        unique case (step_r)
          4'd0: begin
            mul_a = MUL_W'(l2_w);
            mul_b = LOG10_2_Q30;
          end
          4'd1: begin
            rl_nxt = rl_w[18:0];
            mul_a  = MUL_W'($signed(item_r.temperature));
            mul_b  = MUL_W'($signed(item_r.temperature));
          end
          4'd2: begin
            t2_nxt = mul_p[31:0];
            mul_a  = MUL_W'(rl_r);
            mul_b  = MUL_W'(rl_r);
          end
          4'd3: begin
            rl2_nxt = mul_p[32:12];
            mul_a   = COEF_A2;
            mul_b   = $signed({1'b0, t2_r});
          end
          4'd4: begin
            pa_nxt = prod_sra16[34:0];
            mul_a  = COEF_A1;
            mul_b  = MUL_W'($signed(item_r.temperature));
          end
          4'd5: begin
            pa_nxt = pa_r + $signed(prod_sra8[34:0]) + COEF_A0;
            mul_a  = COEF_B2;
            mul_b  = $signed({1'b0, t2_r});
          end
          4'd6: begin
            pb_nxt = prod_sra16[34:0];
            mul_a  = COEF_B1;
            mul_b  = MUL_W'($signed(item_r.temperature));
          end
          4'd7: begin
            pb_nxt = pb_r + $signed(prod_sra8[34:0]) + COEF_B0;
            mul_a  = COEF_C2;
            mul_b  = $signed({1'b0, t2_r});
          end
          4'd8: begin
            pc_nxt = prod_sra16[34:0];
            mul_a  = COEF_C1;
            mul_b  = MUL_W'($signed(item_r.temperature));
          end
          4'd9: begin
            pc_nxt = pc_r + $signed(prod_sra8[34:0]) + COEF_C0;
            mul_a  = $signed(pa_r[32:0]);
            mul_b  = $signed({12'd0, rl2_r});
          end
          4'd10: begin
            acc_nxt = $signed(mul_p[51:0]);
            mul_a   = $signed(pb_r[32:0]);
            mul_b   = MUL_W'(rl_r);
          end
          default: begin
            acc_nxt   = acc_r - $signed(mul_p[51:0]) + $signed({pc_r, 12'd0});
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_FINISH: begin
        res_nxt          = '0;
        res_nxt.done_res = 1'b1;
        priority if (acc_r > HUNDRED_Q36) begin
          res_nxt.humidity = 15'd25600;
        end else if (acc_r < 0) begin
          res_nxt.humidity = '0;
        end else begin
          res_nxt.humidity = rnd_w[42:28];
        end
        range_nxt     = '0;
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      range_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      range_r     <= range_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    nz_r   <= nz_nxt;
    p_r    <= p_nxt;
    z_r    <= z_nxt;
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    pass_r <= pass_nxt;
    step_r <= step_nxt;
    rl_r   <= rl_nxt;
    t2_r   <= t2_nxt;
    rl2_r  <= rl2_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    pc_r   <= pc_nxt;
    acc_r  <= acc_nxt;
  end

  `AHC_ASSERT_NOW(a_res_when_idle, res_valid_r, state_r == S_IDLE, "result while busy")
  `AHC_ASSERT_NOW(a_range_bound, 1'b1, {1'b0, range_r} < 4'(RANGE_COUNT), "range out of bounds")
  `AHC_ASSERT_NOW(a_err_done, res_valid_r && res_r.discharge_error,
    res_r.done_res && res_r.next_range == '0 && res_r.humidity == '0, "bad error result")

endmodule

/* design/autorange_humidity_converter.sv */
// A discharge error or a range step is resolved in S_CHECK and passes through the sequencer's
// result register into the output register; a full conversion's length is set by the shared 33x33
// multiplier, the one-bit-a-cycle normalization and the two bitwise log2 passes
// (a square state and a wait state per fraction bit).
// Throughput: one request at a time; the next is taken once the result register is empty.
// Reset (rst_n low, synchronous): idle, range back to 0, offset 0, threshold 512.
`include "autorange_humidity_converter_macros.svh"

module autorange_humidity_converter
  import ahc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // discharge_residual, charged_sample, temperature, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // humidity, next_range, pad
  output logic        out_tlast,  // done_res
  output logic        out_tuser,  // discharge_error
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic signed [15:0] offset_r;
  logic [9:0]         thr_r;
  logic               out_valid_r;
  ahc_res_t           out_res_r;

  logic      busy, res_valid, start;
  ahc_res_t  res;
  ahc_item_t item;

  assign item.residual    = in_tdata[9:0];
  assign item.sample      = in_tdata[19:10];
  assign item.temperature = in_tdata[35:20];

  // Hold off while busy, while a finished result is on its way into the output register, or while it is full
  assign in_tready = !busy && !res_valid && !out_valid_r;
  assign start     = in_tvalid && in_tready;

  ahc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (item),
    .log_offset (offset_r),
    .threshold  (thr_r),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      thr_r    <= 10'd512;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOG_OFFSET: offset_r <= $signed(cfg_wdata);
        CFG_THRESHOLD:  thr_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.next_range, out_res_r.humidity};
  assign out_tlast  = out_res_r.done_res;
  assign out_tuser  = out_res_r.discharge_error;

  `AHC_ASSERT_NEXT(a_busy_after_accept, start, !in_tready, "ready right after accept")
  `AHC_ASSERT_NOW(a_result_fits, res_valid, !out_valid_r, "result register occupied")

endmodule

/* sim/tb_autorange_humidity_converter.sv */
`default_nettype none

module tb_autorange_humidity_converter;
  import ahc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [9:0]  residual;
    logic [9:0]  sample;
    logic [15:0] temperature;
  } meas_req_t;

  typedef struct {
    logic [14:0] humidity;
    logic        done_res;
    logic [2:0]  next_range;
    logic        discharge_error;
  } meas_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  autorange_humidity_converter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  longint    pred_offset;
  longint    pred_threshold;
  int        pred_range;

  meas_req_t pending_reqs[$];
  meas_res_t expected_results[$];
  int        errors;
  int        accepted_reqs;
  int        checked_results;
  int        finished_count;
  int        error_count;
  longint    cycle_count;
  bit        sender_pause;
  int        hold_off;
  bit        hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint log2_frac16(longint unsigned v);
    int p;
    longint unsigned t;
    longint unsigned z;
    longint unsigned r;
    p = 0;
    t = v;
    if (v == 0) return 0;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    z = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    r = longint'(p) << 16;
    for (int k = 15; k >= 0; k--) begin
      z = (z * z) >> 30;
      if (z >= (64'd2 << 30)) begin
        z = z >> 1;
        r = r | (64'd1 << k);
      end
    end
    return longint'(r);
  endfunction

  function automatic longint temp_poly(longint c0, longint c1, longint c2, longint t);
    return floor_shift(c2 * t * t, 16) + floor_shift(c1 * t, 8) + c0;
  endfunction

  function automatic meas_res_t convert_measurement(meas_req_t rq);
    meas_res_t res;
    longint s;
    longint t;
    longint a;
    longint unsigned y;
    longint l2;
    longint lg10;
    longint rl;
    longint rl2;
    longint pa;
    longint pb;
    longint pc;
    longint rh;
    bit is_last;
    res = '{humidity: '0, done_res: 1'b0, next_range: '0, discharge_error: 1'b0};
    s = rq.sample;
    t = longint'($signed(rq.temperature));
    if (rq.residual > RESIDUAL_LIMIT) begin
      pred_range = 0;
      res.done_res = 1'b1;
      res.discharge_error = 1'b1;
      return res;
    end
    is_last = (pred_range + 1 >= RANGE_COUNT);
    if (s <= pred_threshold && !is_last) begin
      pred_range = (pred_range + 1) & 7;
      res.next_range = pred_range[2:0];
      return res;
    end
    if (s != 0) begin
      a = ADC_BITS * 65536 - log2_frac16(1024 - s);
      y = longint'(a) * 744261118;
      l2 = log2_frac16(y) - (longint'(46) << 16);
      lg10 = floor_shift(l2 * 323228497 + (longint'(1) << 33), 34);
      rl = pred_offset - lg10 + (longint'(pred_range) << 12);
      rl2 = floor_shift(rl * rl, 12);
      pa = temp_poly(64'sd21224856, 64'sd932813, -64'sd11744, t);
      pb = temp_poly(64'sd621277086, 64'sd6397152, -64'sd46976, t);
      pc = temp_poly(64'sd3471373763, 64'sd766719, -64'sd60398, t);
      rh = pa * rl2 - pb * rl + pc * 4096;
      if (rh > (longint'(100) << 36)) res.humidity = 15'd25600;
      else if (rh < 0) res.humidity = '0;
      else res.humidity = 15'((rh + (longint'(1) << 27)) >>> 28);
    end
    pred_range = 0;
    res.done_res = 1'b1;
    return res;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the offered request
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0 && !sender_pause) begin
      meas_req_t rq;
      rq = pending_reqs.pop_front();
      in_tdata <= {4'b0, rq.temperature, rq.sample, rq.residual};
      in_tvalid <= 1'b1;
      in_gap <= gap_length();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      meas_req_t rq;
      meas_res_t res;
      rq.residual = in_tdata[9:0];
      rq.sample = in_tdata[19:10];
      rq.temperature = in_tdata[35:20];
      res = convert_measurement(rq);
      expected_results.push_back(res);
      accepted_reqs++;
    end
  end

  // Receiver readiness
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else if (hold_request) begin
      out_tready <= 1'b0;
      if (hold_off > 0) hold_off <= hold_off - 1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      out_gap <= gap_length();
      out_tready <= (gap_length() == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      meas_res_t got;
      meas_res_t exp_res;
      got.humidity = out_tdata[14:0];
      got.next_range = out_tdata[17:15];
      got.done_res = out_tlast;
      got.discharge_error = out_tuser;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result hum=%0d", $time, got.humidity);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (got.humidity !== exp_res.humidity) begin
          $display("%0t: humidity exp %0d got %0d", $time, exp_res.humidity, got.humidity);
          errors++;
        end
        if (got.done_res !== exp_res.done_res) begin
          $display("%0t: done exp %0d got %0d", $time, exp_res.done_res, got.done_res);
          errors++;
        end
        if (got.next_range !== exp_res.next_range) begin
          $display("%0t: next_range exp %0d got %0d", $time, exp_res.next_range,
                   got.next_range);
          errors++;
        end
        if (got.discharge_error !== exp_res.discharge_error) begin
          $display("%0t: discharge_error exp %0d got %0d", $time,
                   exp_res.discharge_error, got.discharge_error);
          errors++;
        end
        if (exp_res.done_res) finished_count++;
        if (exp_res.discharge_error) error_count++;
      end
      checked_results++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL autorange_humidity_converter");
      $finish;
    end
  end

  task automatic write_reg(logic addr, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_LOG_OFFSET) pred_offset = longint'($signed(value));
    else pred_threshold = value[9:0];
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic add_req(int residual, int sample, int temperature);
    meas_req_t rq;
    rq.residual = residual[9:0];
    rq.sample = sample[9:0];
    rq.temperature = temperature[15:0];
    pending_reqs.push_back(rq);
  endtask

  function automatic int rand_temp();
    return $urandom_range(0, 32000) - 10240;
  endfunction

  // A run of up to five requests with random content, sometimes broken by a discharge error
  task automatic add_sequence();
    int steps;
    steps = $urandom_range(0, 5);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 19) == 0)
        add_req($urandom_range(5, 1023), $urandom_range(0, 1023), rand_temp());
      else
        add_req($urandom_range(0, 4), $urandom_range(0, 1023), rand_temp());
    end
  endtask

  initial begin
    int offsets[4];
    int thresholds[4];
    errors = 0;
    accepted_reqs = 0;
    checked_results = 0;
    finished_count = 0;
    error_count = 0;
    cycle_count = 0;
    sender_pause = 1'b0;
    hold_request = 1'b0;
    hold_off = 0;
    pred_offset = 0;
    pred_threshold = 512;
    pred_range = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_LOG_OFFSET;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, then field extremes
    add_req(0, 1023, 0);
    add_req(4, 0, 0);
    add_req(5, 600, 0);
    add_req(1023, 1023, -10240);
    for (int i = 0; i < 5; i++) add_req(0, 0, 21760);
    for (int i = 0; i < 5; i++) add_req(3, 1, -10240);
    add_req(0, 513, 21760);
    add_req(0, 512, 6400);
    add_req(2, 1023, -32768);
    add_req(1, 700, 32767);
    wait_drained();

    offsets = '{-32768, 32767, 12000, -4000};
    thresholds = '{0, 1023, 300, 900};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_LOG_OFFSET, 16'(offsets[ph]));
      write_reg(CFG_THRESHOLD, 16'(thresholds[ph]));
      add_req(0, 1023, 5000);
      add_req(0, 1, 5000);
      add_req(0, thresholds[ph], -256);
      wait_drained();
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_LOG_OFFSET, 16'($urandom_range(0, 65535)));
      write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 1023)));
      if (ph == 2) begin
        hold_request = 1'b1;
        hold_off = 400;
        for (int i = 0; i < 20; i++) add_sequence();
        while (hold_off > 0) @(posedge clk);
        hold_request = 1'b0;
      end
      while (pending_reqs.size() < 230) begin
        if ($urandom_range(0, 9) == 0)
          add_req($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535));
        else
          add_sequence();
      end
      if (ph == 5) begin
        while (pending_reqs.size() > 120) @(posedge clk);
        sender_pause = 1'b1;
        while (in_tvalid || expected_results.size() > 0) @(posedge clk);
        sender_pause = 1'b0;
      end
      wait_drained();
    end

    $display("requests %0d, results %0d, finished %0d, discharge errors %0d",
             accepted_reqs, checked_results, finished_count, error_count);
    $display("covered register extremes, full ranging sequences and output stalls");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS autorange_humidity_converter");
    end else begin
      $display("FAIL autorange_humidity_converter");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/ahc_pkg.sv
design/ahc_mul.sv
design/ahc_seq.sv
design/autorange_humidity_converter.sv
sim/tb_autorange_humidity_converter.sv
